>>> sv/hdlcd_pkg.sv
// Shared types and constants for the HDLC deframer with CRC-16 check.
`timescale 1ns / 1ps

package hdlcd_pkg;

  localparam int BYTE_W          = 8;
  localparam int CRC_W           = 16;
  localparam int MAXLEN_W        = 10;
  localparam int LEN_W           = 10;
  localparam int KIND_W          = 3;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;
  localparam int COUNT_BITS_DEF  = 10;

  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

  // A frame needs at least this many unstuffed bytes, CRC included.
  localparam int MIN_FRAME_BYTES = 4;
  // Depth of the delay line that holds back the received CRC.
  localparam int HELD_DEPTH      = 2;

  // Configuration register reset values.
  localparam logic [BYTE_W-1:0]   FLAG_RST   = 8'h7E;
  localparam logic [BYTE_W-1:0]   ESCAPE_RST = 8'h7D;
  localparam logic [BYTE_W-1:0]   MASK_RST   = 8'h20;
  localparam logic [CRC_W-1:0]    CRCI_RST   = 16'hFFFF;
  localparam logic [MAXLEN_W-1:0] MAXLEN_RST = 10'd266;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLAG    = 3'd0,
    CFG_ESCAPE  = 3'd1,
    CFG_MASK    = 3'd2,
    CFG_CRCI    = 3'd3,
    CFG_MAXLEN  = 3'd4
  } cfg_idx_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA     = 3'd0,
    KIND_GOOD     = 3'd1,
    KIND_SHORT    = 3'd2,
    KIND_CRC_ERR  = 3'd3,
    KIND_OVERFLOW = 3'd4
  } kind_t;

endpackage

>>> sv/hdlc_deframer_crc_check.sv
// HDLC deframer: flag delimiting, byte unstuffing, CRC-16 check and status report.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Word
// in_       input      in_valid / in_stall  in_line_byte (raw line byte)
// out_      output     out_valid / out_stall out_result_kind, out_data_byte, out_frame_length
// cfg_      input      cfg_we               cfg_index, cfg_data (write only)
//
// The block takes one line byte per clock cycle unless in_stall is high. A byte
// is held in the input register; the deframing, unstuffing and CRC update happen
// in the step from the input register to the result register, so a result word
// reaches the result ports through the input register and then the result register.
// The byte-wide CRC update sets the path.
// Reset is synchronous and active low: the block goes idle and the
// configuration registers return to their defaults.
// A stall on the result side holds the result register and then the input
// register; in_stall rises only when the input register cannot move on.

module hdlc_deframer_crc_check #(
  parameter int COUNT_BITS = hdlcd_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [hdlcd_pkg::BYTE_W-1:0]       in_line_byte,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [hdlcd_pkg::KIND_W-1:0]       out_result_kind,
  output logic [hdlcd_pkg::BYTE_W-1:0]       out_data_byte,
  output logic [hdlcd_pkg::LEN_W-1:0]        out_frame_length,
  // configuration port
  input  logic                               cfg_we,
  input  logic [hdlcd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hdlcd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import hdlcd_pkg::*;

  // Width in which the frame limit and the byte count are compared.
  localparam int CMP_W = (COUNT_BITS > MAXLEN_W) ? COUNT_BITS : MAXLEN_W;
  localparam logic [CMP_W-1:0] COUNT_MAX = CMP_W'((64'd1 << COUNT_BITS) - 64'd1);

  // Configuration registers.
  logic [BYTE_W-1:0]   flag_r;
  logic [BYTE_W-1:0]   escape_r;
  logic [BYTE_W-1:0]   mask_r;
  logic [CRC_W-1:0]    crci_r;
  logic [MAXLEN_W-1:0] maxlen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r   <= FLAG_RST;
      escape_r <= ESCAPE_RST;
      mask_r   <= MASK_RST;
      crci_r   <= CRCI_RST;
      maxlen_r <= MAXLEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FLAG:   flag_r   <= cfg_data[BYTE_W-1:0];
        CFG_ESCAPE: escape_r <= cfg_data[BYTE_W-1:0];
        CFG_MASK:   mask_r   <= cfg_data[BYTE_W-1:0];
        CFG_CRCI:   crci_r   <= cfg_data[CRC_W-1:0];
        CFG_MAXLEN: maxlen_r <= cfg_data[MAXLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              advance;
  logic              in_accept;

  // The input register moves into the result register when that one is
  // empty or is being emptied in the same cycle.
  assign advance   = in_valid_r && (!out_valid || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_byte_r <= in_line_byte;
    end
  end

  // Frame state.
  logic                  in_frame_r,   in_frame_nxt;
  logic                  esc_r,        esc_nxt;
  logic [COUNT_BITS-1:0] count_r,      count_nxt;
  logic [CRC_W-1:0]      crc_r,        crc_nxt;
  logic [BYTE_W-1:0]     held0_r,      held0_nxt;
  logic [BYTE_W-1:0]     held1_r,      held1_nxt;

  logic              res_valid;
  kind_t             res_kind;
  logic [BYTE_W-1:0] res_data;
  logic [LEN_W-1:0]  res_len;

  logic [CRC_W-1:0]  crc_upd;
  logic [CMP_W-1:0]  limit;
  logic [BYTE_W-1:0] ubyte;

  hdlcd_crc_step u_crc_step (
    .crc_in  (crc_r),
    .data_in (held0_r),
    .crc_out (crc_upd)
  );

  // The configured limit never exceeds what the byte counter can hold.
  assign limit = (CMP_W'(maxlen_r) > COUNT_MAX) ? COUNT_MAX : CMP_W'(maxlen_r);

  always_comb begin
    in_frame_nxt = in_frame_r;
    esc_nxt      = esc_r;
    count_nxt    = count_r;
    crc_nxt      = crc_r;
    held0_nxt    = held0_r;
    held1_nxt    = held1_r;
    res_valid    = 1'b0;
    res_kind     = KIND_DATA;
    res_data     = '0;
    res_len      = '0;
    ubyte        = in_byte_r;

    if (in_byte_r == flag_r) begin
      // The flag test comes first, so a flag always delimits, even after an
      // escape byte.
      if (in_frame_r) begin
        res_valid = 1'b1;
        res_len   = LEN_W'(count_r);
        if (count_r < COUNT_BITS'(MIN_FRAME_BYTES)) begin
          res_kind = KIND_SHORT;
        end else if ({held0_r, held1_r} == crc_r) begin
          res_kind = KIND_GOOD;
        end else begin
          res_kind = KIND_CRC_ERR;
        end
        in_frame_nxt = 1'b0;
        esc_nxt      = 1'b0;
      end else begin
        in_frame_nxt = 1'b1;
        esc_nxt      = 1'b0;
        count_nxt    = '0;
        crc_nxt      = crci_r;
        held0_nxt    = '0;
        held1_nxt    = '0;
      end
    end else if (in_frame_r) begin
      if (!esc_r && (in_byte_r == escape_r)) begin
        esc_nxt = 1'b1;
      end else begin
        if (esc_r) begin
          ubyte = in_byte_r ^ mask_r;
        end
        esc_nxt = 1'b0;
        if (CMP_W'(count_r) >= limit) begin
          // The frame is too long: drop this byte and the rest of the frame.
          res_valid    = 1'b1;
          res_kind     = KIND_OVERFLOW;
          res_len      = LEN_W'(count_r);
          in_frame_nxt = 1'b0;
        end else begin
          held0_nxt = held1_r;
          held1_nxt = ubyte;
          count_nxt = count_r + COUNT_BITS'(1);
          // Once the delay line is full, the oldest byte leaves it as data
          // and enters the running CRC.
          if (count_r >= COUNT_BITS'(HELD_DEPTH)) begin
            crc_nxt   = crc_upd;
            res_valid = 1'b1;
            res_kind  = KIND_DATA;
            res_data  = held0_r;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      esc_r      <= 1'b0;
      count_r    <= '0;
      crc_r      <= CRCI_RST;
      held0_r    <= '0;
      held1_r    <= '0;
    end else if (advance) begin
      in_frame_r <= in_frame_nxt;
      esc_r      <= esc_nxt;
      count_r    <= count_nxt;
      crc_r      <= crc_nxt;
      held0_r    <= held0_nxt;
      held1_r    <= held1_nxt;
    end
  end

  // Result register.
  logic              out_valid_r;
  kind_t             out_kind_r;
  logic [BYTE_W-1:0] out_data_r;
  logic [LEN_W-1:0]  out_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_kind_r <= res_kind;
      out_data_r <= res_data;
      out_len_r  <= res_len;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_data_byte    = out_data_r;
  assign out_frame_length = out_len_r;

  // A data word never carries a length, and a status word never a data byte.
  a_fields_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_kind_r == KIND_DATA) ? (out_len_r == '0) : (out_data_r == '0)))
    else $error("result word mixes data and status fields");

  // Inside a frame the byte count never runs past the limit.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (in_frame_r && !cfg_we && !$past(cfg_we)) |-> (CMP_W'(count_r) <= limit))
    else $error("byte count beyond frame limit");

  // Any status word closes the frame.
  a_status_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_valid && (res_kind != KIND_DATA)) |=> !in_frame_r)
    else $error("frame still open after status word");

  // An empty input register never holds off the line.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> !in_stall)
    else $error("input stalled with empty input register");

endmodule

>>> sv/hdlcd_crc_step.sv
// One byte-wide CRC-16 update, polynomial 0x1021, MSB first.
`timescale 1ns / 1ps

module hdlcd_crc_step (
  input  logic [hdlcd_pkg::CRC_W-1:0]  crc_in,
  input  logic [hdlcd_pkg::BYTE_W-1:0] data_in,
  output logic [hdlcd_pkg::CRC_W-1:0]  crc_out
);
  import hdlcd_pkg::*;

  always_comb begin
    logic [CRC_W-1:0] c;
    c = crc_in ^ {data_in, {(CRC_W-BYTE_W){1'b0}}};
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

>>> tb/sv/hdlcd_result_checker.sv
// Result checker for the HDLC deframer: predicts each result word and compares it.
`timescale 1ns / 1ps

module hdlcd_result_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [hdlcd_pkg::BYTE_W-1:0]     in_line_byte,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [hdlcd_pkg::KIND_W-1:0]     out_result_kind,
  input  logic [hdlcd_pkg::BYTE_W-1:0]     out_data_byte,
  input  logic [hdlcd_pkg::LEN_W-1:0]      out_frame_length,
  input  logic                             cfg_we,
  input  logic [hdlcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hdlcd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                               fail_count,
  output int                               pending_count
);
  import hdlcd_pkg::*;

  typedef struct packed {
    kind_t               kind;
    logic [BYTE_W-1:0]   data;
    logic [LEN_W-1:0]    len;
  } frame_result_t;

  localparam int unsigned LEN_CAP = (1 << COUNT_BITS_DEF) - 1;

  logic [BYTE_W-1:0]   flag_r;
  logic [BYTE_W-1:0]   esc_r;
  logic [BYTE_W-1:0]   mask_r;
  logic [CRC_W-1:0]    crc_init_r;
  logic [MAXLEN_W-1:0] max_len_r;

  logic                in_frame;
  logic                esc_pending;
  int unsigned         byte_cnt;
  logic [CRC_W-1:0]    crc_acc;
  logic [BYTE_W-1:0]   held [HELD_DEPTH];

  frame_result_t       results_due [$];

  // CRC-16, polynomial 0x1021, MSB first, one byte at a time.
  function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // Advances the deframer state by one line byte and queues the result it causes.
  task automatic deframe_byte(input logic [BYTE_W-1:0] raw);
    logic [BYTE_W-1:0] b;
    int unsigned       limit;
    kind_t             k;
    b = raw;
    if (b == flag_r) begin
      if (in_frame) begin
        if (byte_cnt < MIN_FRAME_BYTES) begin
          k = KIND_SHORT;
        end else if ({held[0], held[1]} == crc_acc) begin
          k = KIND_GOOD;
        end else begin
          k = KIND_CRC_ERR;
        end
        results_due.push_back('{k, '0, LEN_W'(byte_cnt)});
        in_frame    = 1'b0;
        esc_pending = 1'b0;
      end else begin
        in_frame    = 1'b1;
        esc_pending = 1'b0;
        byte_cnt    = 0;
        crc_acc     = crc_init_r;
        held[0]     = '0;
        held[1]     = '0;
      end
      return;
    end
    if (!in_frame) return;
    if (esc_pending) begin
      b           = b ^ mask_r;
      esc_pending = 1'b0;
    end else if (b == esc_r) begin
      esc_pending = 1'b1;
      return;
    end
    limit = (max_len_r > LEN_CAP) ? LEN_CAP : max_len_r;
    if (byte_cnt >= limit) begin
      results_due.push_back('{KIND_OVERFLOW, '0, LEN_W'(byte_cnt)});
      in_frame    = 1'b0;
      esc_pending = 1'b0;
      return;
    end
    if (byte_cnt >= 2) begin
      crc_acc = crc16_byte(crc_acc, held[0]);
      results_due.push_back('{KIND_DATA, held[0], '0});
    end
    held[0]  = held[1];
    held[1]  = b;
    byte_cnt = byte_cnt + 1;
  endtask

  always @(posedge clk) begin : watch
    frame_result_t due;
    if (!rst_n) begin
      flag_r      = FLAG_RST;
      esc_r       = ESCAPE_RST;
      mask_r      = MASK_RST;
      crc_init_r  = CRCI_RST;
      max_len_r   = MAXLEN_RST;
      in_frame    = 1'b0;
      esc_pending = 1'b0;
      byte_cnt    = 0;
      crc_acc     = CRCI_RST;
      held[0]     = '0;
      held[1]     = '0;
      results_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_FLAG:   flag_r     = cfg_data[BYTE_W-1:0];
          CFG_ESCAPE: esc_r      = cfg_data[BYTE_W-1:0];
          CFG_MASK:   mask_r     = cfg_data[BYTE_W-1:0];
          CFG_CRCI:   crc_init_r = cfg_data[CRC_W-1:0];
          CFG_MAXLEN: max_len_r  = cfg_data[MAXLEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) deframe_byte(in_line_byte);
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result word, kind %0d data %02h length %0d",
                   $time, out_result_kind, out_data_byte, out_frame_length);
          fail_count++;
        end else begin
          due = results_due.pop_front();
          if (out_result_kind !== due.kind) begin
            $display("%0t: result kind expected %0d, got %0d",
                     $time, due.kind, out_result_kind);
            fail_count++;
          end
          if (out_data_byte !== due.data) begin
            $display("%0t: data byte expected %02h, got %02h",
                     $time, due.data, out_data_byte);
            fail_count++;
          end
          if (out_frame_length !== due.len) begin
            $display("%0t: frame length expected %0d, got %0d",
                     $time, due.len, out_frame_length);
            fail_count++;
          end
        end
      end
    end
    pending_count <= results_due.size();
  end

endmodule

>>> tb/sv/tb_hdlc_deframer_crc_check.sv
// Testbench top for the HDLC deframer: stimulus, handshake pacing and the verdict.
`timescale 1ns / 1ps

module tb_hdlc_deframer_crc_check;
  import hdlcd_pkg::*;

  // Cycles to let an in-flight word that causes no result clear the pipeline
  // (input register plus result register, with margin).
  localparam int SETTLE_CYCLES = 8;
  // Length of the one long hold-off on the result side.
  localparam int HOLD_CYCLES   = 300;

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic [BYTE_W-1:0]     in_line_byte = '0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic [KIND_W-1:0]     out_result_kind;
  logic [BYTE_W-1:0]     out_data_byte;
  logic [LEN_W-1:0]      out_frame_length;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  int fail_count;
  int pending_count;

  // Our own view of the configuration, used only to shape the line traffic.
  logic [BYTE_W-1:0] cur_flag     = FLAG_RST;
  logic [BYTE_W-1:0] cur_esc      = ESCAPE_RST;
  logic [BYTE_W-1:0] cur_mask     = MASK_RST;
  logic [CRC_W-1:0]  cur_crc_init = CRCI_RST;
  int                cur_max      = MAXLEN_RST;

  logic [BYTE_W-1:0] frame_data [$];  // unstuffed payload of the next frame
  logic [BYTE_W-1:0] line_words [$];  // stuffed line bytes of the next frame
  int                frame_words = 0; // line words sent inside frames so far
  bit                sender_calm = 1'b0;
  bit                hold_req    = 1'b0;
  bit                hold_done   = 1'b0;

  hdlc_deframer_crc_check i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_line_byte     (in_line_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_data_byte    (out_data_byte),
    .out_frame_length (out_frame_length),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  hdlcd_result_checker i_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_line_byte     (in_line_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_data_byte    (out_data_byte),
    .out_frame_length (out_frame_length),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pending_count    (pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // The sender needs its own CRC to build frames that should pass the check.
  function automatic logic [CRC_W-1:0] crc_next(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // A byte can go on the line as it is when it is neither the flag nor the escape.
  function automatic bit raw_ok(input logic [BYTE_W-1:0] w);
    return (w != cur_flag) && (w != cur_esc);
  endfunction

  // Escaping only works when the escape differs from the flag and the masked
  // byte does not itself look like a flag, since the flag test comes first.
  function automatic bit stuff_ok(input logic [BYTE_W-1:0] w);
    return (cur_esc != cur_flag) && ((w ^ cur_mask) != cur_flag);
  endfunction

  // Payload bytes lean toward the flag and escape values so that stuffing
  // gets exercised, but only bytes that can actually be carried are kept.
  function automatic logic [BYTE_W-1:0] pick_data_word();
    logic [BYTE_W-1:0] w;
    case ($urandom_range(0, 9))
      0:       w = cur_flag;
      1:       w = cur_esc;
      2:       w = cur_flag ^ cur_mask;
      default: w = 8'($urandom);
    endcase
    while (!(raw_ok(w) || stuff_ok(w))) w = 8'($urandom);
    return w;
  endfunction

  // Appends one unstuffed byte to the line. A CRC byte that cannot be carried
  // is sent raw anyway and simply breaks the frame.
  function automatic void stuff_word(input logic [BYTE_W-1:0] w);
    if (raw_ok(w)) begin
      line_words.push_back(w);
    end else if (stuff_ok(w)) begin
      line_words.push_back(cur_esc);
      line_words.push_back(w ^ cur_mask);
    end else begin
      line_words.push_back(w);
    end
  endfunction

  // Offers one word and returns once it has been accepted. The valid is only
  // lowered when a gap is taken, so it never drops and rises in one step.
  task automatic send_word(input logic [BYTE_W-1:0] w);
    int gap;
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_line_byte <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Sends frame_data as a frame: opening flag, stuffed payload, optional CRC
  // (optionally corrupted), optional dangling escape, closing flag.
  task automatic send_frame(input bit with_crc, input bit bad_crc, input bit esc_end);
    logic [CRC_W-1:0] crc;
    crc = cur_crc_init;
    line_words.delete();
    line_words.push_back(cur_flag);
    foreach (frame_data[i]) begin
      crc = crc_next(crc, frame_data[i]);
      stuff_word(frame_data[i]);
    end
    if (bad_crc) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    if (with_crc) begin
      stuff_word(crc[15:8]);
      stuff_word(crc[7:0]);
    end
    if (esc_end && (cur_esc != cur_flag)) line_words.push_back(cur_esc);
    line_words.push_back(cur_flag);
    // About one frame in four goes out back to back with no gaps at all.
    sender_calm = ($urandom_range(0, 3) == 0);
    foreach (line_words[i]) send_word(line_words[i]);
    frame_words += line_words.size();
  endtask

  // Register writes happen only once the block has drained: every predicted
  // result has come out, and a word that causes no result has had time to clear.
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FLAG:   cur_flag     = val[BYTE_W-1:0];
      CFG_ESCAPE: cur_esc      = val[BYTE_W-1:0];
      CFG_MASK:   cur_mask     = val[BYTE_W-1:0];
      CFG_CRCI:   cur_crc_init = val[CRC_W-1:0];
      CFG_MAXLEN: cur_max      = int'(val[MAXLEN_W-1:0]);
      default: ;
    endcase
  endtask

  // Random traffic until about budget more line words have gone into frames.
  // Most frames are well formed; the rest carry a bad CRC, are too short,
  // run past the length limit, end on an escape, or are noise between frames.
  task automatic run_frames(input int budget, input int max_payload);
    int target;
    int r;
    int n;
    bit with_crc;
    bit bad_crc;
    bit esc_end;
    target = frame_words + budget;
    while (frame_words < target) begin
      r        = $urandom_range(0, 99);
      n        = $urandom_range(0, max_payload);
      with_crc = 1'b1;
      bad_crc  = 1'b0;
      esc_end  = 1'b0;
      if (r < 55) begin
        // plain good frame
      end else if (r < 65) begin
        // exactly as long as the limit allows
        if (cur_max >= 2 && cur_max <= 64) n = cur_max - 2;
      end else if (r < 72) begin
        // one byte past the limit
        if (cur_max <= 64) n = (cur_max >= 1) ? cur_max - 1 : 0;
      end else if (r < 80) begin
        bad_crc = 1'b1;
      end else if (r < 87) begin
        with_crc = 1'b0;
        n        = $urandom_range(0, 3);
      end else if (r < 93) begin
        esc_end = 1'b1;
      end else begin
        // Noise while idle: the block ignores it, so it is not counted.
        sender_calm = 1'b0;
        repeat ($urandom_range(1, 4)) begin
          logic [BYTE_W-1:0] w;
          w = 8'($urandom);
          while (w == cur_flag) w = 8'($urandom);
          send_word(w);
        end
        continue;
      end
      frame_data.delete();
      repeat (n) frame_data.push_back(pick_data_word());
      send_frame(with_crc, bad_crc, esc_end);
    end
  endtask

  // Result side: runs of acceptance broken by stalls of random length, with
  // one long hold-off while the sender keeps pushing, so the block backs up.
  initial begin : result_sink
    int run;
    int hold;
    int r;
    wait (rst_n);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
      out_stall <= 1'b0;
      repeat (run) @(posedge clk);
      if (hold_req && !hold_done) begin
        hold      = HOLD_CYCLES;
        hold_done = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70)      hold = $urandom_range(1, 3);
        else if (r < 95) hold = $urandom_range(4, 12);
        else             hold = $urandom_range(20, 60);
      end
      out_stall <= 1'b1;
      repeat (hold) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [BYTE_W-1:0] v;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words under the reset configuration.
    // Bytes outside a frame are ignored, including the all-zero and all-one bytes.
    send_word(8'h00);
    send_word(8'hFF);
    // A good frame whose payload holds a flag value, so it needs an escape.
    frame_data = '{8'hFF, 8'h7E, 8'h00};
    send_frame(1'b1, 1'b0, 1'b0);
    // A single byte fills the delay line only, then the frame is too short.
    frame_data = '{8'h01};
    send_frame(1'b0, 1'b0, 1'b0);
    // Two flags in a row: an empty frame.
    frame_data.delete();
    send_frame(1'b0, 1'b0, 1'b0);
    // A corrupted CRC followed by an escape right before the closing flag:
    // the flag still closes the frame and the CRC error is reported.
    frame_data = '{8'h00, 8'h11, 8'h22};
    send_frame(1'b1, 1'b1, 1'b1);

    // Random traffic under the reset configuration, with the long hold-off.
    hold_req = 1'b1;
    run_frames(200, 24);

    // Low extremes of every register; a limit of four leaves room for little.
    write_reg(CFG_FLAG, 16'h0000);
    write_reg(CFG_ESCAPE, 16'h00FF);
    write_reg(CFG_MASK, 16'h00FF);
    write_reg(CFG_CRCI, 16'h0000);
    write_reg(CFG_MAXLEN, 16'd4);
    run_frames(50, 2);

    // High extremes: largest limit, a mask of zero makes escaping a no-op copy.
    write_reg(CFG_FLAG, 16'h00FF);
    write_reg(CFG_ESCAPE, 16'h0000);
    write_reg(CFG_MASK, 16'h0000);
    write_reg(CFG_CRCI, 16'hFFFF);
    write_reg(CFG_MAXLEN, 16'd1023);
    // One frame that runs into the full-size limit.
    frame_data.delete();
    repeat (1022) frame_data.push_back(pick_data_word());
    send_frame(1'b1, 1'b0, 1'b0);
    write_reg(CFG_CRCI, 16'($urandom));
    run_frames(50, 30);

    // A limit of zero: the first byte of every frame overflows.
    write_reg(CFG_MAXLEN, 16'd0);
    run_frames(20, 6);

    // Escape equal to the flag: the escape can never act.
    write_reg(CFG_FLAG, 16'h007E);
    write_reg(CFG_ESCAPE, 16'h007E);
    write_reg(CFG_MASK, 16'h0020);
    write_reg(CFG_MAXLEN, 16'd64);
    run_frames(50, 20);

    // Fully random settings, twice.
    repeat (2) begin
      v = 8'($urandom);
      write_reg(CFG_FLAG, {8'h00, v});
      write_reg(CFG_ESCAPE, {8'h00, ($urandom_range(0, 7) == 0) ? v : 8'($urandom)});
      write_reg(CFG_MASK, 16'($urandom_range(0, 255)));
      write_reg(CFG_CRCI, 16'($urandom));
      write_reg(CFG_MAXLEN, 16'($urandom_range(5, 40)));
      run_frames(40, 24);
    end

    // Back to the reset values.
    write_reg(CFG_FLAG, 16'(FLAG_RST));
    write_reg(CFG_ESCAPE, 16'(ESCAPE_RST));
    write_reg(CFG_MASK, 16'(MASK_RST));
    write_reg(CFG_CRCI, 16'(CRCI_RST));
    write_reg(CFG_MAXLEN, 16'(MAXLEN_RST));
    run_frames(40, 24);

    // Drain: wait for every expected word, then SETTLE_CYCLES more so that a
    // stray extra result would still be caught.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin : watchdog
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> files.f
sv/hdlcd_pkg.sv
sv/hdlcd_crc_step.sv
sv/hdlc_deframer_crc_check.sv
tb/sv/hdlcd_result_checker.sv
tb/sv/tb_hdlc_deframer_crc_check.sv
